// ===== hw/rtl/sra_pkg.sv =====
// Package for the selective-repeat ARQ engine.
// Holds sequence constants, action and step codes, control structs and helpers.
// No dependencies.
package sra_pkg;

    localparam int SEQ_W     = 6;
    localparam int SEQ_SPACE = 64;
    localparam int WINDOW    = 32;
    localparam int CNT_W     = 7;

    localparam logic [2:0] KIND_PACKET  = 3'd0;
    localparam logic [2:0] KIND_PHY_RDY = 3'd1;
    localparam logic [2:0] KIND_FRAME   = 3'd2;
    localparam logic [2:0] KIND_DATA_TO = 3'd3;
    localparam logic [2:0] KIND_ACK_TO  = 3'd4;

    localparam logic [1:0] FT_DATA = 2'd0;
    localparam logic [1:0] FT_ACK  = 2'd1;
    localparam logic [1:0] FT_NAK  = 2'd2;

    localparam logic [2:0] ACT_DATA    = 3'd0;
    localparam logic [2:0] ACT_ACK     = 3'd1;
    localparam logic [2:0] ACT_NAK     = 3'd2;
    localparam logic [2:0] ACT_RELEASE = 3'd3;
    localparam logic [2:0] ACT_STORE   = 3'd4;
    localparam logic [2:0] ACT_DELIVER = 3'd5;
    localparam logic [2:0] ACT_STATUS  = 3'd6;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_EXEC    = 4'd1;
    localparam logic [3:0] ST_TAKEACK = 4'd2;
    localparam logic [3:0] ST_DATA    = 4'd3;
    localparam logic [3:0] ST_DATA2   = 4'd4;
    localparam logic [3:0] ST_DELIV   = 4'd5;
    localparam logic [3:0] ST_SCAN    = 4'd6;
    localparam logic [3:0] ST_STATUS  = 4'd7;

    typedef struct packed {
        logic       load;
        logic       en;
        logic [3:0] step;
    } sra_cmd_t;

    typedef struct packed {
        logic       go;
        logic [2:0] kind;
        logic       good;
        logic [1:0] ftype;
        logic       nak;
        logic       data_in_win;
        logic       s_is_base;
        logic       deliv_more;
        logic       scan_more;
        logic       map_nx;
        logic       clearing;
    } sra_stat_t;

    // true when b lies in the circular interval [a, c)
    function automatic logic in_range(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b,
                                      input logic [SEQ_W-1:0] c);
        in_range = (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
    endfunction

endpackage

// ===== hw/rtl/sra_if.sv =====
// Channel interfaces for the ARQ engine: link events in, commands out.
// Depends on nothing beyond plain logic types.
interface sra_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic       frame_good;
    logic [1:0] frame_type;
    logic [5:0] frame_seq;
    logic [5:0] peer_ack;
    logic [5:0] timer_seq;

    modport source (output valid, kind, frame_good, frame_type, frame_seq, peer_ack,
                    timer_seq, input ready);
    modport sink (input valid, kind, frame_good, frame_type, frame_seq, peer_ack,
                  timer_seq, output ready);
endinterface

interface sra_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [5:0] seq;
    logic [5:0] ack;
    logic [5:0] count;
    logic       net_enable;
    logic       last;

    modport source (output valid, action, seq, ack, count, net_enable, last, input ready);
    modport sink (input valid, action, seq, ack, count, net_enable, last, output ready);
endinterface

// ===== hw/rtl/sra_ctrl.sv =====
// Controller state machine of the ARQ engine.
// Depends on sra_pkg; drives sra_dp through sra_cmd_t.
module sra_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              evt_valid,
    output logic              evt_ready,
    input  sra_pkg::sra_stat_t stat,
    output sra_pkg::sra_cmd_t  cmd
);
    import sra_pkg::*;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // hold the input off while the bitmap clearing pass runs
    assign evt_ready = (state_reg == ST_IDLE) && !stat.clearing;

    always_comb
    begin
        cmd.load = evt_ready && evt_valid;
        cmd.en   = (state_reg != ST_IDLE) && stat.go;
        cmd.step = state_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (evt_valid && !stat.clearing)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.go)
                begin
                    if (stat.kind == KIND_FRAME && stat.good &&
                        (stat.ftype == FT_DATA || stat.ftype == FT_ACK))
                    begin
                        state_next = ST_TAKEACK;
                    end
                    else
                    begin
                        state_next = ST_STATUS;
                    end
                end
            end
            ST_TAKEACK:
            begin
                if (stat.go)
                begin
                    state_next = (stat.ftype == FT_DATA) ? ST_DATA : ST_STATUS;
                end
            end
            ST_DATA:
            begin
                if (stat.go)
                begin
                    state_next = stat.data_in_win ? ST_DATA2 : ST_STATUS;
                end
            end
            ST_DATA2:
            begin
                if (stat.go)
                begin
                    state_next = stat.s_is_base ? ST_DELIV : ST_STATUS;
                end
            end
            ST_DELIV:
            begin
                if (stat.go && !stat.deliv_more)
                begin
                    state_next = stat.nak ? ST_STATUS : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.go && (!stat.scan_more || stat.map_nx))
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (stat.go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/sra_dp.sv =====
// Datapath of the ARQ engine: window state, arrived bitmap, output register,
// and the generic registered-read RAM that holds the bitmap.
// Depends on sra_pkg; steered by sra_ctrl.
module sra_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  sra_pkg::sra_cmd_t  cmd,
    output sra_pkg::sra_stat_t stat,
    input  logic [2:0]        kind,
    input  logic              frame_good,
    input  logic [1:0]        frame_type,
    input  logic [5:0]        frame_seq,
    input  logic [5:0]        peer_ack,
    input  logic [5:0]        timer_seq,
    input  logic              res_ready,
    output logic              res_valid,
    output logic [2:0]        action,
    output logic [5:0]        seq,
    output logic [5:0]        ack,
    output logic [5:0]        count,
    output logic              net_enable,
    output logic              last
);
    import sra_pkg::*;

    logic [2:0]       kind_reg;
    logic             good_reg;
    logic [1:0]       ftype_reg;
    logic [SEQ_W-1:0] fseq_reg, fack_reg, tseq_reg;

    logic [SEQ_W-1:0] send_base_reg, send_base_next;
    logic [SEQ_W-1:0] next_send_reg, next_send_next;
    logic [SEQ_W-1:0] recv_base_reg, recv_base_next;
    logic [SEQ_W-1:0] recv_limit_reg, recv_limit_next;
    logic [SEQ_W-1:0] outstanding_reg, outstanding_next;
    logic             nak_reg, nak_next;
    logic             phy_reg, phy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SEQ_W-1:0] nx_reg, nx_next;
    logic [SEQ_W:0]   clr_reg, clr_next;

    logic             valid_reg, valid_next;
    logic [2:0]       act_reg, act_next;
    logic [SEQ_W-1:0] seq_reg, seq_next, ack_reg, ack_next, count_reg, count_next;
    logic             ne_reg, ne_next, last_reg, last_next;

    logic             emit;
    logic [SEQ_W-1:0] ack_num;
    logic [CNT_W-1:0] rel_n;
    logic             go;

    logic             clearing;
    logic             map_we;
    logic [SEQ_W-1:0] map_waddr;
    logic             map_wdata;
    logic             ram_we;
    logic [SEQ_W-1:0] ram_waddr;
    logic             ram_wdata;
    logic [SEQ_W-1:0] ram_raddr;
    logic             map_rd;

    assign go      = !valid_reg || res_ready;
    assign ack_num = recv_base_reg - SEQ_W'(1);
    assign rel_n   = CNT_W'(SEQ_W'(fack_reg - send_base_reg)) + CNT_W'(1);

    // clearing pass: one bitmap entry per cycle after reset
    assign clearing = !clr_reg[SEQ_W];
    assign clr_next = clearing ? clr_reg + (SEQ_W+1)'(1) : clr_reg;

    assign ram_we    = clearing || map_we;
    assign ram_waddr = clearing ? clr_reg[SEQ_W-1:0] : map_waddr;
    assign ram_wdata = clearing ? 1'b0 : map_wdata;

    always_comb
    begin
        stat.go          = go;
        stat.kind        = kind_reg;
        stat.good        = good_reg;
        stat.ftype       = ftype_reg;
        stat.nak         = nak_reg;
        stat.data_in_win = in_range(recv_base_reg, fseq_reg, recv_limit_reg);
        stat.s_is_base   = (fseq_reg == recv_base_reg);
        stat.deliv_more  = (cnt_reg < CNT_W'(WINDOW)) && map_rd;
        stat.scan_more   = (cnt_reg < CNT_W'(SEQ_SPACE)) && (nx_reg != recv_limit_reg);
        stat.map_nx      = map_rd;
        stat.clearing    = clearing;
    end

    // present the address whose entry the next step needs
    always_comb
    begin
        case (cmd.step)
            ST_DATA2: ram_raddr = recv_base_reg;
            ST_DELIV: ram_raddr = go ? recv_base_reg + SEQ_W'(1) : recv_base_reg;
            ST_SCAN:  ram_raddr = go ? nx_reg + SEQ_W'(1) : nx_reg;
            default:  ram_raddr = fseq_reg;
        endcase
    end

    sra_ram #(
        .WIDTH (1),
        .DEPTH (SEQ_SPACE)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (map_rd)
    );

    always_comb
    begin
        send_base_next   = send_base_reg;
        next_send_next   = next_send_reg;
        recv_base_next   = recv_base_reg;
        recv_limit_next  = recv_limit_reg;
        outstanding_next = outstanding_reg;
        nak_next         = nak_reg;
        phy_next         = phy_reg;
        cnt_next         = cnt_reg;
        nx_next          = nx_reg;
        map_we           = 1'b0;
        map_waddr        = fseq_reg;
        map_wdata        = 1'b0;
        emit             = 1'b0;
        act_next         = act_reg;
        seq_next         = '0;
        ack_next         = '0;
        count_next       = '0;
        ne_next          = 1'b0;
        last_next        = 1'b0;
        if (cmd.en)
        begin
            case (cmd.step)
                ST_EXEC:
                begin
                    case (kind_reg)
                        KIND_PACKET:
                        begin
                            if (outstanding_reg != SEQ_W'(SEQ_SPACE - 1))
                            begin
                                outstanding_next = outstanding_reg + SEQ_W'(1);
                            end
                            emit           = 1'b1;
                            act_next       = ACT_DATA;
                            seq_next       = next_send_reg;
                            ack_next       = ack_num;
                            phy_next       = 1'b0;
                            next_send_next = next_send_reg + SEQ_W'(1);
                        end
                        KIND_PHY_RDY:
                        begin
                            phy_next = 1'b1;
                        end
                        KIND_FRAME:
                        begin
                            if (!good_reg)
                            begin
                                if (!nak_reg)
                                begin
                                    emit     = 1'b1;
                                    act_next = ACT_NAK;
                                    ack_next = recv_base_reg;
                                    phy_next = 1'b0;
                                    nak_next = 1'b1;
                                end
                            end
                            else if (ftype_reg == FT_NAK &&
                                     in_range(send_base_reg, fack_reg, next_send_reg))
                            begin
                                emit     = 1'b1;
                                act_next = ACT_DATA;
                                seq_next = fack_reg;
                                ack_next = ack_num;
                                phy_next = 1'b0;
                            end
                        end
                        KIND_DATA_TO:
                        begin
                            if (in_range(send_base_reg, tseq_reg, next_send_reg))
                            begin
                                emit     = 1'b1;
                                act_next = ACT_DATA;
                                seq_next = tseq_reg;
                                ack_next = ack_num;
                                phy_next = 1'b0;
                            end
                        end
                        KIND_ACK_TO:
                        begin
                            emit     = 1'b1;
                            act_next = ACT_ACK;
                            ack_next = ack_num;
                            phy_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_TAKEACK:
                begin
                    if (in_range(send_base_reg, fack_reg, next_send_reg))
                    begin
                        outstanding_next = (CNT_W'(outstanding_reg) > rel_n) ?
                                           outstanding_reg - rel_n[SEQ_W-1:0] : '0;
                        send_base_next   = fack_reg + SEQ_W'(1);
                        emit             = 1'b1;
                        act_next         = ACT_RELEASE;
                        seq_next         = send_base_reg;
                        count_next       = rel_n[SEQ_W-1:0];
                    end
                end
                ST_DATA:
                begin
                    if (!stat.data_in_win)
                    begin
                        emit     = 1'b1;
                        act_next = ACT_ACK;
                        ack_next = ack_num;
                        phy_next = 1'b0;
                    end
                    else if (!map_rd)
                    begin
                        map_we    = 1'b1;
                        map_waddr = fseq_reg;
                        map_wdata = 1'b1;
                        emit      = 1'b1;
                        act_next  = ACT_STORE;
                        seq_next  = fseq_reg;
                    end
                end
                ST_DATA2:
                begin
                    cnt_next = '0;
                    if (!stat.s_is_base && !nak_reg)
                    begin
                        nak_next = 1'b1;
                        emit     = 1'b1;
                        act_next = ACT_NAK;
                        ack_next = recv_base_reg;
                        phy_next = 1'b0;
                    end
                end
                ST_DELIV:
                begin
                    if (stat.deliv_more)
                    begin
                        emit            = 1'b1;
                        act_next        = ACT_DELIVER;
                        seq_next        = recv_base_reg;
                        map_we          = 1'b1;
                        map_waddr       = recv_base_reg;
                        map_wdata       = 1'b0;
                        recv_base_next  = recv_base_reg + SEQ_W'(1);
                        recv_limit_next = recv_limit_reg + SEQ_W'(1);
                        nak_next        = 1'b0;
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        nx_next  = recv_base_reg + SEQ_W'(1);
                        cnt_next = '0;
                    end
                end
                ST_SCAN:
                begin
                    if (stat.scan_more)
                    begin
                        if (map_rd)
                        begin
                            emit     = 1'b1;
                            act_next = ACT_NAK;
                            ack_next = recv_base_reg;
                            phy_next = 1'b0;
                            nak_next = 1'b1;
                        end
                        else
                        begin
                            nx_next  = nx_reg + SEQ_W'(1);
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                end
                ST_STATUS:
                begin
                    emit      = 1'b1;
                    act_next  = ACT_STATUS;
                    ne_next   = (outstanding_reg < SEQ_W'(WINDOW)) && phy_reg;
                    last_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (emit)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && !res_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_base_reg   <= '0;
            next_send_reg   <= '0;
            recv_base_reg   <= '0;
            recv_limit_reg  <= SEQ_W'(WINDOW % SEQ_SPACE);
            outstanding_reg <= '0;
            nak_reg         <= 1'b0;
            phy_reg         <= 1'b0;
            cnt_reg         <= '0;
            nx_reg          <= '0;
            clr_reg         <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            send_base_reg   <= send_base_next;
            next_send_reg   <= next_send_next;
            recv_base_reg   <= recv_base_next;
            recv_limit_reg  <= recv_limit_next;
            outstanding_reg <= outstanding_next;
            nak_reg         <= nak_next;
            phy_reg         <= phy_next;
            cnt_reg         <= cnt_next;
            nx_reg          <= nx_next;
            clr_reg         <= clr_next;
            valid_reg       <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            good_reg  <= frame_good;
            ftype_reg <= frame_type;
            fseq_reg  <= frame_seq;
            fack_reg  <= peer_ack;
            tseq_reg  <= timer_seq;
        end
        if (emit)
        begin
            act_reg   <= act_next;
            seq_reg   <= seq_next;
            ack_reg   <= ack_next;
            count_reg <= count_next;
            ne_reg    <= ne_next;
            last_reg  <= last_next;
        end
    end

    assign res_valid  = valid_reg;
    assign action     = act_reg;
    assign seq        = seq_reg;
    assign ack        = ack_reg;
    assign count      = count_reg;
    assign net_enable = ne_reg;
    assign last       = last_reg;

endmodule

// Generic single-write, single-read RAM with registered read data.
module sra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/selective_repeat_arq_engine.sv =====
// Selective-repeat ARQ engine, 64-number sequence space, window of 32.
// One step per cycle while the output accepts results; one item at a time.
// An item takes longer while the output stalls; the delivery walk (up to 32 steps)
// and NAK scan (up to 31 steps) over the bitmap set how long an item takes.
// Reset (rst_n low, asynchronous): windows at their start; a clearing pass over all 64
// entries of the arrived bitmap follows, with the input held off until it ends.
module selective_repeat_arq_engine (
    input  logic clk,
    input  logic rst_n,
    sra_evt_if.sink   evt,
    sra_res_if.source res
);
    import sra_pkg::*;

    sra_cmd_t  cmd;
    sra_stat_t stat;

    // controller: sequences the steps of one event, holds while the output waits
    sra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .evt_ready (evt.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: window edges, arrived bitmap and the result register
    sra_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (evt.kind),
        .frame_good (evt.frame_good),
        .frame_type (evt.frame_type),
        .frame_seq  (evt.frame_seq),
        .peer_ack   (evt.peer_ack),
        .timer_seq  (evt.timer_seq),
        .res_ready  (res.ready),
        .res_valid  (res.valid),
        .action     (res.action),
        .seq        (res.seq),
        .ack        (res.ack),
        .count      (res.count),
        .net_enable (res.net_enable),
        .last       (res.last)
    );

endmodule
